### hw/rtl/cbf_pkg.sv
// Shared constants, codes and types of the counting Bloom filter.
`default_nettype none
package cbf_pkg;

  localparam int CBF_COUNTERS   = 4096;
  localparam int CBF_MAX_HASHES = 8;
  localparam int CBF_COUNT_BITS = 16;

  localparam logic [63:0] HASH_SEED = 64'h0000_0000_dead_beef;
  localparam logic [63:0] MM_C1     = 64'h87c3_7b91_1142_53d5;
  localparam logic [63:0] MM_C2     = 64'h4cf5_ad43_2745_937f;
  localparam logic [63:0] FMIX_C1   = 64'hff51_afd7_ed55_8ccd;
  localparam logic [63:0] FMIX_C2   = 64'hc4ce_b9fe_1a85_ec53;
  localparam logic [63:0] KEY_LEN   = 64'd4;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_HASH_COUNT      = 2'd0,
    CFG_COUNTERS_IN_USE = 2'd1,
    CFG_COUNT_LIMIT     = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    HS_IDLE, HS_K1, HS_K2, HS_AB, HS_ADD1, HS_ADD2, HS_FA1, HS_FA2,
    HS_FB1, HS_FB2, HS_ADD3, HS_ADD4, HS_DONE
  } hash_state_t;

  typedef enum logic [2:0] {
    TS_CLEAR, TS_IDLE, TS_HASH, TS_MSTART, TS_MOD, TS_READ, TS_MODIFY, TS_RESP
  } top_state_t;

  typedef struct packed {
    logic        done;
    logic [63:0] h1;
    logic [63:0] h2;
  } hash_res_t;

endpackage
`default_nettype wire

### hw/rtl/counting_bloom_filter.sv
// Top level of the counting Bloom filter over DRAM row addresses.
// Usage:
//   Input beats (in_cmd, in_row_addr) are taken when in_valid is high and
//   in_stall is low. Each beat gives exactly one result beat (out_present,
//   out_saturated), taken when out_valid is high and out_stall is low.
//   Configuration writes use cfg_valid/cfg_ready (ready is always high) with
//   cfg_index 0 hash_count, 1 counters_in_use, 2 count_limit; other indexes
//   are ignored. Write configuration only while the block is idle.
// Processing:
//   One item at a time. The hash runs on the shared 32x32 multiplier, then
//   each probe takes these steps: a restart of the remainder unit, the
//   remainder (eight bits a cycle of the 64-bit probe value, then its done
//   flag), a read and a read-modify-write. The result goes to the output
//   register after the last probe and the next beat can be taken once it
//   is loaded; an unknown command or zero probes skips the hash.
// Reset:
//   rst_n is synchronous. After reset the counter RAM is cleared one entry
//   per cycle, all COUNTERS entries, and in_stall stays high during the sweep.
// Stall:
//   The result sits in an output register; while out_stall is high it holds
//   and a finished item waits for the register before the next is taken.
`default_nettype none
module counting_bloom_filter #(
  parameter int COUNTERS   = cbf_pkg::CBF_COUNTERS,
  parameter int MAX_HASHES = cbf_pkg::CBF_MAX_HASHES,
  parameter int COUNT_BITS = cbf_pkg::CBF_COUNT_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [31:0] in_row_addr,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic        out_present,
  output      logic        out_saturated,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  localparam int IW = $clog2(COUNTERS);
  localparam int MW = $clog2(COUNTERS + 1);
  localparam int PW = $clog2(MAX_HASHES + 1);
  localparam logic [31:0] CMAX32 = 32'((64'd1 << COUNT_BITS) - 64'd1);

  // Configuration registers.
  logic [3:0]  hash_count_r;
  logic [12:0] counters_in_use_r;
  logic [15:0] count_limit_r;

  cbf_pkg::top_state_t state_r, state_nxt;
  logic [IW-1:0]         clr_addr_r;
  logic [1:0]            cmd_r;
  logic [PW-1:0]         probes_r, n_r, probes_in;
  logic [MW-1:0]         m_r, m_in;
  logic [COUNT_BITS-1:0] limit_r, limit_in;
  logic [63:0]           s_r, h2_r;
  logic                  present_r, sat_r;
  logic                  out_valid_r, out_present_r, out_saturated_r;

  logic                  accept, skip, load_out, last_probe;
  cbf_pkg::hash_res_t    hres;
  logic                  mod_done;
  logic [MW-1:0]         mod_rem;
  logic                  ram_we, ram_re;
  logic [IW-1:0]         ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata, ram_rdata, cval;
  logic                  upd_we, zero_seen, sat_seen;
  logic [COUNT_BITS-1:0] upd_val;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != cbf_pkg::TS_IDLE);
  assign cfg_ready = 1'b1;

  // Clamp the configuration into the ranges the datapath supports.
  always_comb begin
    if (32'(hash_count_r) > 32'(MAX_HASHES)) begin
      probes_in = PW'(MAX_HASHES);
    end else begin
      probes_in = PW'(hash_count_r);
    end
    if (counters_in_use_r == 13'd0) begin
      m_in = MW'(1);
    end else if (32'(counters_in_use_r) > 32'(COUNTERS)) begin
      m_in = MW'(COUNTERS);
    end else begin
      m_in = MW'(counters_in_use_r);
    end
    if (32'(count_limit_r) < CMAX32) begin
      limit_in = COUNT_BITS'(count_limit_r);
    end else begin
      limit_in = COUNT_BITS'(CMAX32);
    end
  end

  // Unknown commands and zero probes touch no counter.
  assign skip       = (in_cmd == cbf_pkg::CMD_NONE) || (probes_in == '0);
  assign load_out   = (state_r == cbf_pkg::TS_RESP) && (!out_valid_r || !out_stall);
  assign last_probe = (n_r + PW'(1)) == probes_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cbf_pkg::TS_CLEAR:  if (clr_addr_r == IW'(COUNTERS - 1)) state_nxt = cbf_pkg::TS_IDLE;
      cbf_pkg::TS_IDLE: begin
        if (accept) begin
          state_nxt = skip ? cbf_pkg::TS_RESP : cbf_pkg::TS_HASH;
        end
      end
      cbf_pkg::TS_HASH:   if (hres.done) state_nxt = cbf_pkg::TS_MSTART;
      cbf_pkg::TS_MSTART: state_nxt = cbf_pkg::TS_MOD;
      cbf_pkg::TS_MOD:    if (mod_done) state_nxt = cbf_pkg::TS_READ;
      cbf_pkg::TS_READ:   state_nxt = cbf_pkg::TS_MODIFY;
      cbf_pkg::TS_MODIFY: state_nxt = last_probe ? cbf_pkg::TS_RESP : cbf_pkg::TS_MSTART;
      cbf_pkg::TS_RESP:   if (load_out) state_nxt = cbf_pkg::TS_IDLE;
      default:            state_nxt = cbf_pkg::TS_CLEAR;
    endcase
  end

  // Counter update for the probe whose value has just come out of the RAM.
  assign cval = ram_rdata;
  always_comb begin
    upd_we    = 1'b0;
    upd_val   = cval;
    zero_seen = (cval == '0);
    sat_seen  = 1'b0;
    case (cmd_r)
      cbf_pkg::CMD_ADD: begin
        if (cval >= limit_r) begin
          sat_seen = 1'b1;
        end else begin
          upd_we  = 1'b1;
          upd_val = cval + COUNT_BITS'(1);
        end
      end
      cbf_pkg::CMD_DELETE: begin
        if (cval != '0) begin
          upd_we  = 1'b1;
          upd_val = cval - COUNT_BITS'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = mod_rem[IW-1:0];
    ram_wdata = upd_val;
    ram_re    = (state_r == cbf_pkg::TS_READ);
    case (state_r)
      cbf_pkg::TS_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
      end
      cbf_pkg::TS_MODIFY: ram_we = upd_we;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= cbf_pkg::TS_CLEAR;
      clr_addr_r        <= '0;
      hash_count_r      <= 4'd3;
      counters_in_use_r <= 13'd4096;
      count_limit_r     <= 16'hffff;
      out_valid_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == cbf_pkg::TS_CLEAR) begin
        clr_addr_r <= clr_addr_r + IW'(1);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cbf_pkg::CFG_HASH_COUNT:      hash_count_r      <= cfg_wdata[3:0];
          cbf_pkg::CFG_COUNTERS_IN_USE: counters_in_use_r <= cfg_wdata[12:0];
          cbf_pkg::CFG_COUNT_LIMIT:     count_limit_r     <= cfg_wdata;
          default: ;
        endcase
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      cmd_r     <= in_cmd;
      probes_r  <= probes_in;
      m_r       <= m_in;
      limit_r   <= limit_in;
      n_r       <= '0;
      present_r <= 1'b1;
      sat_r     <= 1'b0;
    end
    if (state_r == cbf_pkg::TS_HASH && hres.done) begin
      s_r  <= hres.h1;
      h2_r <= hres.h2;
    end
    if (state_r == cbf_pkg::TS_MODIFY) begin
      n_r <= n_r + PW'(1);
      s_r <= s_r + h2_r;
      if (zero_seen) present_r <= 1'b0;
      if (sat_seen) sat_r <= 1'b1;
    end
    if (load_out) begin
      out_present_r   <= (cmd_r == cbf_pkg::CMD_QUERY) && present_r;
      out_saturated_r <= (cmd_r == cbf_pkg::CMD_ADD) && sat_r;
    end
  end

  cbf_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == cbf_pkg::TS_IDLE && accept && !skip),
    .key   (in_row_addr),
    .res   (hres)
  );

  cbf_mod #(.COUNTERS(COUNTERS)) u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (state_r == cbf_pkg::TS_MSTART),
    .value   (s_r),
    .modulus (m_r),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  cbf_ram #(.WIDTH(COUNT_BITS), .DEPTH(COUNTERS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (mod_rem[IW-1:0]),
    .rdata (ram_rdata)
  );

  assign out_valid     = out_valid_r;
  assign out_present   = out_present_r;
  assign out_saturated = out_saturated_r;

`ifndef SYNTHESIS
  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == cbf_pkg::TS_HASH) || (state_r == cbf_pkg::TS_RESP))
    else $error("accepted beat did not start hashing or respond");
  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cbf_pkg::TS_MODIFY) |-> (n_r < probes_r))
    else $error("probe count ran past the number of probes");
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cbf_pkg::TS_READ) |-> (mod_rem < m_r))
    else $error("counter index not below the modulus");
  a_mod_done: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == cbf_pkg::TS_MOD))
    else $error("remainder finished outside its wait state");
`endif

endmodule
`default_nettype wire

### hw/rtl/cbf_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module cbf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/cbf_hash.sv
// Multi-cycle MurmurHash3 x64 128 of a four-byte key on one shared 32x32 multiplier.
`default_nettype none
module cbf_hash (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [31:0]       key,
  output      cbf_pkg::hash_res_t res
);

  cbf_pkg::hash_state_t state_r, state_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [63:0] x_r, x_nxt, a_r, a_nxt, b_r, b_nxt, acc_r, acc_nxt;
  logic [63:0] cst;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p, sum, p;
  logic        is_mul;

  // A 64-bit truncated product takes three partial products, one per cycle.
  always_comb begin
    case (state_r)
      cbf_pkg::HS_K1:  cst = cbf_pkg::MM_C1;
      cbf_pkg::HS_K2:  cst = cbf_pkg::MM_C2;
      cbf_pkg::HS_FA1: cst = cbf_pkg::FMIX_C1;
      cbf_pkg::HS_FB1: cst = cbf_pkg::FMIX_C1;
      cbf_pkg::HS_FA2: cst = cbf_pkg::FMIX_C2;
      cbf_pkg::HS_FB2: cst = cbf_pkg::FMIX_C2;
      default:         cst = 64'h0;
    endcase
  end

  assign is_mul = (state_r == cbf_pkg::HS_K1) || (state_r == cbf_pkg::HS_K2) ||
                  (state_r == cbf_pkg::HS_FA1) || (state_r == cbf_pkg::HS_FA2) ||
                  (state_r == cbf_pkg::HS_FB1) || (state_r == cbf_pkg::HS_FB2);
  assign mul_a = (ph_r == 2'd2) ? x_r[63:32] : x_r[31:0];
  assign mul_b = (ph_r == 2'd1) ? cst[63:32] : cst[31:0];
  assign mul_p = mul_a * mul_b;
  assign sum   = acc_r + {mul_p[31:0], 32'h0};
  assign p     = sum;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cbf_pkg::HS_IDLE: if (start) state_nxt = cbf_pkg::HS_K1;
      cbf_pkg::HS_K1:   if (ph_r == 2'd2) state_nxt = cbf_pkg::HS_K2;
      cbf_pkg::HS_K2:   if (ph_r == 2'd2) state_nxt = cbf_pkg::HS_AB;
      cbf_pkg::HS_AB:   state_nxt = cbf_pkg::HS_ADD1;
      cbf_pkg::HS_ADD1: state_nxt = cbf_pkg::HS_ADD2;
      cbf_pkg::HS_ADD2: state_nxt = cbf_pkg::HS_FA1;
      cbf_pkg::HS_FA1:  if (ph_r == 2'd2) state_nxt = cbf_pkg::HS_FA2;
      cbf_pkg::HS_FA2:  if (ph_r == 2'd2) state_nxt = cbf_pkg::HS_FB1;
      cbf_pkg::HS_FB1:  if (ph_r == 2'd2) state_nxt = cbf_pkg::HS_FB2;
      cbf_pkg::HS_FB2:  if (ph_r == 2'd2) state_nxt = cbf_pkg::HS_ADD3;
      cbf_pkg::HS_ADD3: state_nxt = cbf_pkg::HS_ADD4;
      cbf_pkg::HS_ADD4: state_nxt = cbf_pkg::HS_DONE;
      cbf_pkg::HS_DONE: state_nxt = cbf_pkg::HS_IDLE;
      default:          state_nxt = cbf_pkg::HS_IDLE;
    endcase
  end

  always_comb begin
    x_nxt   = x_r;
    a_nxt   = a_r;
    b_nxt   = b_r;
    acc_nxt = acc_r;
    ph_nxt  = 2'd0;
    if (is_mul && ph_r != 2'd2) begin
      ph_nxt  = ph_r + 2'd1;
      acc_nxt = (ph_r == 2'd0) ? mul_p : sum;
    end
    case (state_r)
      cbf_pkg::HS_IDLE: x_nxt = {32'h0, key};
      cbf_pkg::HS_K1:   if (ph_r == 2'd2) x_nxt = {p[32:0], p[63:33]};
      cbf_pkg::HS_K2:   if (ph_r == 2'd2) x_nxt = p;
      cbf_pkg::HS_AB: begin
        a_nxt = cbf_pkg::HASH_SEED ^ x_r ^ cbf_pkg::KEY_LEN;
        b_nxt = cbf_pkg::HASH_SEED ^ cbf_pkg::KEY_LEN;
      end
      cbf_pkg::HS_ADD1: a_nxt = a_r + b_r;
      cbf_pkg::HS_ADD2: begin
        b_nxt = b_r + a_r;
        x_nxt = a_r ^ (a_r >> 33);
      end
      cbf_pkg::HS_FA1:  if (ph_r == 2'd2) x_nxt = p ^ (p >> 33);
      cbf_pkg::HS_FA2: begin
        if (ph_r == 2'd2) begin
          a_nxt = p ^ (p >> 33);
          x_nxt = b_r ^ (b_r >> 33);
        end
      end
      cbf_pkg::HS_FB1:  if (ph_r == 2'd2) x_nxt = p ^ (p >> 33);
      cbf_pkg::HS_FB2:  if (ph_r == 2'd2) b_nxt = p ^ (p >> 33);
      cbf_pkg::HS_ADD3: a_nxt = a_r + b_r;
      cbf_pkg::HS_ADD4: b_nxt = b_r + a_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cbf_pkg::HS_IDLE;
      ph_r    <= 2'd0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
    end
    x_r   <= x_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign res.done = (state_r == cbf_pkg::HS_DONE);
  assign res.h1   = a_r;
  assign res.h2   = b_r;

endmodule
`default_nettype wire

### hw/rtl/cbf_mod.sv
// Iterative remainder of a 64-bit value by a narrow modulus, eight bits per cycle.
`default_nettype none
module cbf_mod #(
  parameter int COUNTERS = cbf_pkg::CBF_COUNTERS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [63:0]                    value,
  input  wire logic [$clog2(COUNTERS+1)-1:0]  modulus,
  output      logic                           done,
  output      logic [$clog2(COUNTERS+1)-1:0]  rem
);

  localparam int MW = $clog2(COUNTERS + 1);

  logic [63:0]   val_r, val_nxt;
  logic [MW-1:0] rem_r, rem_nxt;
  logic [2:0]    cnt_r;
  logic          busy_r, done_r;
  logic [MW:0]   t;

  // Restoring steps: remainder stays below the modulus, so one subtract suffices.
  always_comb begin
    t       = '0;
    rem_nxt = rem_r;
    val_nxt = val_r;
    if (start) begin
      rem_nxt = '0;
      val_nxt = value;
    end else if (busy_r) begin
      for (int i = 0; i < 8; i++) begin
        t = {rem_nxt, val_nxt[63]};
        if (t >= {1'b0, modulus}) begin
          t = t - {1'b0, modulus};
        end
        rem_nxt = t[MW-1:0];
        val_nxt = {val_nxt[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= busy_r && (cnt_r == 3'd7);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 3'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          busy_r <= 1'b0;
        end
      end
    end
    rem_r <= rem_nxt;
    val_r <= val_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

### test/counting_bloom_filter_tb.sv
// Self-checking testbench for the counting Bloom filter top level.
`timescale 1ns / 1ps
`default_nettype none
module counting_bloom_filter_tb;
  import cbf_pkg::*;

  // One command beat as the driver offers it.
  typedef struct {
    cmd_t        cmd;
    logic [31:0] row;
  } row_cmd_t;

  // The flags that one command beat should produce.
  typedef struct {
    logic present;
    logic saturated;
  } filter_flags_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 160;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = CMD_QUERY;
  logic [31:0] in_row_addr = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_present;
  logic        out_saturated;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_HASH_COUNT;
  logic [15:0] cfg_wdata = '0;

  // Beats still waiting to be offered, and flags still waiting to come back.
  row_cmd_t      row_queue[$];
  filter_flags_t flags_due[$];

  // Shadow copy of the filter: counters and the three registers.
  logic [15:0] shadow_counts[CBF_COUNTERS];
  logic [3:0]  shadow_hashes = 4'd3;
  logic [12:0] shadow_modulus = 13'd4096;
  logic [15:0] shadow_limit = 16'hffff;

  int errors = 0;
  int beats_sent = 0;
  int beats_back = 0;
  int idle_cycles = 0;
  int n_add = 0, n_query = 0, n_delete = 0, n_none = 0;
  int n_sat_seen = 0, n_hit_seen = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_ticket = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int stall_phase = 0;
  logic in_taken = 1'b0;
  logic [31:0] key_pool[8];

  always #5 clk = ~clk;

  counting_bloom_filter u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_row_addr  (in_row_addr),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_present  (out_present),
    .out_saturated(out_saturated),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    for (int i = 0; i < CBF_COUNTERS; i++) shadow_counts[i] = '0;
  end

  // MurmurHash3 x64 128 of a four byte key followed by double hashing over
  // the shadow counters. Applies the command to the shadow state and returns
  // the flags the block must report.
  function automatic filter_flags_t bloom_apply(input cmd_t cmd, input logic [31:0] key);
    filter_flags_t f;
    logic [63:0]   k, a, b, idx, modulus, probes, n;
    logic [15:0]   c;
    f.present = 1'b1;
    f.saturated = 1'b0;
    if (cmd == CMD_NONE) begin
      f.present = 1'b0;
      return f;
    end
    k = {32'd0, key} * MM_C1;
    k = {k[32:0], k[63:33]};
    k = k * MM_C2;
    a = HASH_SEED ^ k ^ KEY_LEN;
    b = HASH_SEED ^ KEY_LEN;
    a = a + b;
    b = b + a;
    a = a ^ (a >> 33); a = a * FMIX_C1; a = a ^ (a >> 33); a = a * FMIX_C2; a = a ^ (a >> 33);
    b = b ^ (b >> 33); b = b * FMIX_C1; b = b ^ (b >> 33); b = b * FMIX_C2; b = b ^ (b >> 33);
    a = a + b;
    b = b + a;
    // Register values out of range are clamped the same way the block does.
    modulus = (shadow_modulus == 0) ? 64'd1 : 64'(shadow_modulus);
    if (modulus > CBF_COUNTERS) modulus = CBF_COUNTERS;
    probes = (shadow_hashes > CBF_MAX_HASHES) ? 64'(CBF_MAX_HASHES) : 64'(shadow_hashes);
    for (n = 0; n < probes; n++) begin
      idx = (a + n * b) % modulus;
      c = shadow_counts[idx];
      if (cmd == CMD_ADD) begin
        if (c >= shadow_limit) f.saturated = 1'b1;
        else shadow_counts[idx] = c + 16'd1;
      end else if (cmd == CMD_QUERY) begin
        if (c == 0) f.present = 1'b0;
      end else if (c != 0) begin
        shadow_counts[idx] = c - 16'd1;
      end
    end
    if (cmd != CMD_QUERY) f.present = 1'b0;
    return f;
  endfunction

  // Monitor: everything is sampled at the rising edge. Result beats are
  // checked first, then an accepted command beat is folded into the shadow
  // filter, then a register write updates the shadow registers.
  always @(posedge clk) begin
    filter_flags_t want;
    logic          moved;
    moved = 1'b0;
    in_taken = 1'b0;
    if (rst_n && out_valid && !out_stall) begin
      moved = 1'b1;
      beats_back++;
      if (flags_due.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected: present %b saturated %b",
                 $time, out_present, out_saturated);
      end else begin
        want = flags_due.pop_front();
        if (out_present !== want.present) begin
          errors++;
          $display("%0t: present mismatch: expected %b, got %b",
                   $time, want.present, out_present);
        end
        if (out_saturated !== want.saturated) begin
          errors++;
          $display("%0t: saturated mismatch: expected %b, got %b",
                   $time, want.saturated, out_saturated);
        end
        if (out_present === 1'b1) n_hit_seen++;
        if (out_saturated === 1'b1) n_sat_seen++;
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      moved = 1'b1;
      in_taken = 1'b1;
      beats_sent++;
      case (cmd_t'(in_cmd))
        CMD_ADD:    n_add++;
        CMD_QUERY:  n_query++;
        CMD_DELETE: n_delete++;
        default:    n_none++;
      endcase
      flags_due.push_back(bloom_apply(cmd_t'(in_cmd), in_row_addr));
    end
    if (rst_n && cfg_valid && cfg_ready) begin
      moved = 1'b1;
      case (cfg_idx_t'(cfg_index))
        CFG_HASH_COUNT:      shadow_hashes = cfg_wdata[3:0];
        CFG_COUNTERS_IN_USE: shadow_modulus = cfg_wdata[12:0];
        CFG_COUNT_LIMIT:     shadow_limit = cfg_wdata;
        default: ;
      endcase
    end
    // Watchdog: too long without any beat moving means the block is stuck.
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Driver: works in bursts with random gaps. A beat that was offered but
  // not taken stays on the bus unchanged.
  always @(negedge clk) begin
    row_cmd_t beat;
    if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (row_queue.size() != 0) begin
        beat = row_queue.pop_front();
        in_valid <= 1'b1;
        in_cmd <= beat.cmd;
        in_row_addr <= beat.row;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stalls on a pattern that changes mode at random, and
  // serves long hold-off requests from the sequence below.
  always @(negedge clk) begin
    if (hold_seen != hold_ticket) begin
      hold_seen <= hold_ticket;
      hold_left <= 1500;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 64 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 4) < 3);
        default: out_stall <= stall_phase[0];
      endcase
    end
  end

  task automatic queue_beat(input cmd_t cmd, input logic [31:0] row);
    row_cmd_t beat;
    beat.cmd = cmd;
    beat.row = row;
    row_queue.push_back(beat);
  endtask

  // Random commands, mostly on a small set of keys so that adds, queries
  // and deletes meet each other; the rest use fresh keys.
  task automatic queue_random(input int count);
    int          pick;
    cmd_t        cmd;
    logic [31:0] row;
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) cmd = CMD_ADD;
      else if (pick < 75) cmd = CMD_QUERY;
      else if (pick < 95) cmd = CMD_DELETE;
      else cmd = CMD_NONE;
      row = ($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, 7)] : $urandom();
      queue_beat(cmd, row);
    end
  endtask

  // Register write over the configuration channel; the caller drops valid.
  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Waits until every queued beat went in and every result came back, then
  // leaves room for the longest item before the registers may change.
  task automatic drain();
    wait (row_queue.size() == 0 && flags_due.size() == 0 && !in_valid);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] hashes, input logic [15:0] modulus,
                          input logic [15:0] limit);
    write_reg(CFG_HASH_COUNT, hashes);
    write_reg(CFG_COUNTERS_IN_USE, modulus);
    write_reg(CFG_COUNT_LIMIT, limit);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset values first: the extremes of the key, repeated adds, queries of
    // present and absent keys, a delete on empty counters, unknown command.
    queue_beat(CMD_ADD, 32'h0000_0000);
    queue_beat(CMD_ADD, 32'hffff_ffff);
    queue_beat(CMD_ADD, 32'h1234_5678);
    queue_beat(CMD_ADD, 32'h1234_5678);
    queue_beat(CMD_QUERY, 32'h0000_0000);
    queue_beat(CMD_QUERY, 32'hffff_ffff);
    queue_beat(CMD_QUERY, 32'h1234_5678);
    queue_beat(CMD_QUERY, 32'ha5a5_a5a5);
    queue_beat(CMD_DELETE, 32'h1234_5678);
    queue_beat(CMD_QUERY, 32'h1234_5678);
    queue_beat(CMD_DELETE, 32'h5a5a_5a5a);
    queue_beat(CMD_DELETE, 32'h0000_0000);
    queue_beat(CMD_QUERY, 32'h0000_0000);
    queue_beat(CMD_NONE, 32'hffff_ffff);
    queue_random(140);
    drain();

    // Zero probes: nothing is touched and a query always hits.
    set_regs(16'd0, 16'd4096, 16'hffff);
    queue_beat(CMD_QUERY, 32'h0bad_f00d);
    queue_beat(CMD_ADD, 32'h0bad_f00d);
    queue_beat(CMD_DELETE, 32'h0bad_f00d);
    queue_random(50);
    drain();

    // Probe count above the maximum, modulus above the counter count, and a
    // limit of one so that the second add of a key saturates.
    set_regs(16'd15, 16'd8191, 16'd1);
    queue_beat(CMD_ADD, 32'hcafe_0001);
    queue_beat(CMD_ADD, 32'hcafe_0001);
    queue_beat(CMD_QUERY, 32'hcafe_0001);
    queue_beat(CMD_DELETE, 32'hcafe_0001);
    queue_random(150);
    drain();

    // A single counter takes every probe.
    set_regs(16'd8, 16'd1, 16'd3);
    queue_random(150);
    drain();

    // Modulus zero clamps to one, and a limit of zero blocks every add.
    set_regs(16'd1, 16'd0, 16'd0);
    queue_beat(CMD_ADD, 32'h8000_0000);
    queue_beat(CMD_QUERY, 32'h8000_0000);
    queue_random(100);
    drain();

    // A small odd modulus; the receiver holds off for a long stretch while
    // the sender keeps offering, so the block backs up into its input.
    set_regs(16'd5, 16'd37, 16'd2);
    queue_random(200);
    hold_ticket++;
    drain();

    set_regs(16'd2, 16'd4096, 16'hffff);
    queue_random(150);
    drain();

    set_regs(16'd8, 16'd4095, 16'd10);
    queue_random(150);
    drain();

    $display("Ran %0d adds, %0d queries, %0d deletes, %0d unknown commands over eight settings.",
             n_add, n_query, n_delete, n_none);
    $display("Checked %0d results: %0d query hits, %0d saturated adds.",
             beats_back, n_hit_seen, n_sat_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
